>>> src/axis_argmax_reduce_core_assert.svh
// Assertion macros for the argmax reduction core.
// Included by the top level; no other dependencies.
`ifndef AXIS_ARGMAX_REDUCE_CORE_ASSERT_SVH
`define AXIS_ARGMAX_REDUCE_CORE_ASSERT_SVH
`define AAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define AAR_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/aar_pkg.sv
// Package for the argmax reduction core: widths, defaults and the float compare.
// No dependencies.
package aar_pkg;
   localparam int SAMPLE_W = 32;
   localparam int INDEX_W = 16;
   localparam int REDUCE_CFG_W = 17;
   localparam int INNER_CFG_W = 9;
   localparam int CSR_DATA_W = 17;
   localparam int DEF_MAX_INNER = 256;
   localparam longint DEF_MAX_REDUCE = 65536;

   typedef enum logic [0:0] {
      CSR_REDUCE_LENGTH = 1'b0,
      CSR_INNER_LENGTH = 1'b1
   } csr_index_type;

   // True when a < b as IEEE single values; false for any NaN.
   function automatic logic float_less(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic a_zero;
      logic b_zero;
      logic res;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      if (a_nan || b_nan || (a_zero && b_zero)) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction
endpackage

>>> src/aar_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// No dependencies.
interface aar_stream_if #(parameter int W = 32) (input logic clock);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/aar_counter.sv
// Column and reduce position counters of the argmax core.
// Depends on aar_pkg.
module aar_counter #(
   parameter int MAX_INNER = aar_pkg::DEF_MAX_INNER,
   parameter longint MAX_REDUCE = aar_pkg::DEF_MAX_REDUCE,
   parameter int COL_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
   parameter int POS_W = $clog2(MAX_REDUCE)
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic [aar_pkg::REDUCE_CFG_W-1:0] reduce_length,
   input logic [aar_pkg::INNER_CFG_W-1:0] inner_length,
   output logic [COL_W-1:0] column,
   output logic [POS_W-1:0] position,
   output logic last_r,
   output logic last_c
);
   import aar_pkg::*;
   localparam int CW = COL_W + 1;
   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [63:0] n_eff;
   logic [CW+INNER_CFG_W-1:0] k_eff;

   always_comb begin
      n_eff = (reduce_length == '0) ? 64'd1 : 64'(reduce_length);
      if (n_eff > 64'(MAX_REDUCE)) n_eff = 64'(MAX_REDUCE);
      k_eff = (inner_length == '0) ? (CW+INNER_CFG_W)'(1) : (CW+INNER_CFG_W)'(inner_length);
      if (k_eff > (CW+INNER_CFG_W)'(MAX_INNER)) k_eff = (CW+INNER_CFG_W)'(MAX_INNER);
      last_r = 64'(pos_ff) + 64'd1 >= n_eff;
      last_c = (CW+INNER_CFG_W)'(col_ff) + (CW+INNER_CFG_W)'(1) >= k_eff;
      col_in = col_ff;
      pos_in = pos_ff;
      if (advance) begin
         if (last_c) begin
            col_in = '0;
            pos_in = last_r ? '0 : pos_ff + POS_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         pos_ff <= '0;
      end else begin
         col_ff <= col_in;
         pos_ff <= pos_in;
      end
   end

   assign column = col_ff;
   assign position = pos_ff;
endmodule

>>> src/axis_argmax_reduce_core.sv
// Channel      | Dir | Payload
// req          | in  | sample[31:0]
// rsp          | out | argmax_index[15:0], last_of_group (data[16])
// csr          | in  | index, 17-bit write data
// One beat per cycle while req_ready is high: the table read is registered in a first
// stage and the compare and write-back happen in the second, with same-column
// forwarding between them. A skid register absorbs rsp stalls.
// req_ready drops while the skid register is full or a stalled result is about to fill it.
// Reset clears control state only.
// Top level of the streaming argmax core. Depends on aar_pkg, aar_stream_if, aar_counter
// and the assertion macro header.
`include "axis_argmax_reduce_core_assert.svh"
module axis_argmax_reduce_core #(
   parameter int MAX_INNER = aar_pkg::DEF_MAX_INNER,
   parameter longint MAX_REDUCE = aar_pkg::DEF_MAX_REDUCE
) (
   input logic clock,
   input logic reset,
   aar_stream_if.sink req,
   aar_stream_if.source rsp,
   input logic csr_write_enable,
   input logic [0:0] csr_index,
   input logic [aar_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import aar_pkg::*;
   localparam int COL_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int POS_W = $clog2(MAX_REDUCE);

   logic [REDUCE_CFG_W-1:0] reduce_len_ff;
   logic [INNER_CFG_W-1:0] inner_len_ff;
   logic [SAMPLE_W-1:0] best_val_mem [MAX_INNER];
   logic [POS_W-1:0] best_pos_mem [MAX_INNER];

   logic in_beat;
   logic [COL_W-1:0] column;
   logic [POS_W-1:0] position;
   logic last_r, last_c;

   // stage 1
   logic s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [POS_W-1:0] s1_pos_ff;
   logic s1_last_r_ff, s1_last_c_ff;
   logic [SAMPLE_W-1:0] rd_val_ff;
   logic [POS_W-1:0] rd_pos_ff;

   // stage 2 result
   logic [SAMPLE_W-1:0] cur_val, new_val;
   logic [POS_W-1:0] cur_pos, new_pos;
   logic fwd_hit_ff;
   logic [SAMPLE_W-1:0] fwd_val_ff;
   logic [POS_W-1:0] fwd_pos_ff;

   logic out_valid_ff, out_valid_in;
   logic [INDEX_W:0] out_data_ff, out_data_in;
   logic skid_valid_ff;
   logic [INDEX_W:0] skid_data_ff;
   logic res_valid;
   logic [INDEX_W:0] res_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_len_ff <= REDUCE_CFG_W'(1);
         inner_len_ff <= INNER_CFG_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_REDUCE_LENGTH: reduce_len_ff <= csr_write_data[REDUCE_CFG_W-1:0];
            CSR_INNER_LENGTH: inner_len_ff <= csr_write_data[INNER_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = !skid_valid_ff && !(out_valid_ff && !rsp.ready && res_valid);
   assign in_beat = req.valid && req.ready;

   aar_counter #(.MAX_INNER(MAX_INNER), .MAX_REDUCE(MAX_REDUCE)) u_counter (
      .clock(clock), .reset(reset), .advance(in_beat),
      .reduce_length(reduce_len_ff), .inner_length(inner_len_ff),
      .column(column), .position(position), .last_r(last_r), .last_c(last_c)
   );

   always_comb begin
      cur_val = fwd_hit_ff ? fwd_val_ff : rd_val_ff;
      cur_pos = fwd_hit_ff ? fwd_pos_ff : rd_pos_ff;
      new_val = cur_val;
      new_pos = cur_pos;
      if (s1_pos_ff == '0) begin
         new_val = s1_sample_ff;
         new_pos = '0;
      end else if (float_less(cur_val, s1_sample_ff)) begin
         new_val = s1_sample_ff;
         new_pos = s1_pos_ff;
      end
   end

   // registered read with forwarding from the write in the same cycle
   always_ff @(posedge clock) begin
      if (in_beat) begin
         rd_val_ff <= best_val_mem[column];
         rd_pos_ff <= best_pos_mem[column];
         s1_sample_ff <= req.data;
         s1_col_ff <= column;
         s1_pos_ff <= position;
         s1_last_r_ff <= last_r;
         s1_last_c_ff <= last_c;
      end
      fwd_hit_ff <= in_beat && s1_valid_ff && (s1_col_ff == column);
      fwd_val_ff <= new_val;
      fwd_pos_ff <= new_pos;
      if (s1_valid_ff) begin
         best_val_mem[s1_col_ff] <= new_val;
         best_pos_mem[s1_col_ff] <= new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else s1_valid_ff <= in_beat;
   end

   // output register plus skid
   assign res_valid = s1_valid_ff && s1_last_r_ff;
   assign res_data = {s1_last_c_ff, INDEX_W'(new_pos)};

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      if (!out_valid_ff || rsp.ready) begin
         out_valid_in = skid_valid_ff || res_valid;
         out_data_in = skid_valid_ff ? skid_data_ff : res_data;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (out_valid_ff && !rsp.ready && res_valid) skid_data_ff <= res_data;
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (!out_valid_ff || rsp.ready) skid_valid_ff <= skid_valid_ff && res_valid;
         else skid_valid_ff <= skid_valid_ff || res_valid;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_data_ff;

   `AAR_ASSERT(a_skid_needs_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid full while output empty")
   `AAR_ASSERT(a_no_beat_when_full, clock, reset, !(skid_valid_ff && in_beat), "beat taken with full skid")
   `AAR_ASSERT_RST(a_reset_clears, clock, reset |=> !out_valid_ff && !s1_valid_ff, "reset left state")
endmodule

>>> tb/testbench.sv
// Self-checking testbench for axis_argmax_reduce_core: random and directed float beats
// against a per-column running argmax predictor. Depends on aar_pkg, aar_stream_if and the core.
`timescale 1ns / 100ps
module testbench;
   import aar_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic last;
   } argmax_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [0:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   aar_stream_if #(.W(SAMPLE_W)) req_if (clock);
   aar_stream_if #(.W(INDEX_W + 1)) rsp_if (clock);

   axis_argmax_reduce_core u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   logic [SAMPLE_W-1:0] pending_samples[$];
   argmax_result_type expected_argmax[$];
   logic [31:0] column_best[DEF_MAX_INNER];
   logic [15:0] column_best_at[DEF_MAX_INNER];
   int unsigned column_pos;
   int unsigned reduce_pos;
   logic [REDUCE_CFG_W-1:0] reduce_cfg;
   logic [INNER_CFG_W-1:0] inner_cfg;
   int errors;
   int beats_in;
   int results_out;
   int max_send_gap;
   int max_recv_stall;
   int send_gap;
   int recv_stall;
   logic req_fire;
   logic rsp_fire;
   logic [31:0] last_sample;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Order key for non-NaN floats; both zeros map to the same key.
   function automatic logic [32:0] float_key(input logic [31:0] f);
      logic [31:0] m;
      m = (f[30:0] == 31'd0) ? 32'd0 : f;
      return m[31] ? {1'b0, ~m} : {1'b1, m};
   endfunction

   function automatic logic is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
   endfunction

   task automatic predict_argmax(input logic [31:0] sample);
      int unsigned n;
      int unsigned k;
      int unsigned col;
      logic last_r;
      logic last_c;
      argmax_result_type r;
      n = (reduce_cfg == 0) ? 1 : ((reduce_cfg > 65536) ? 65536 : reduce_cfg);
      k = (inner_cfg == 0) ? 1 : ((inner_cfg > DEF_MAX_INNER) ? DEF_MAX_INNER : inner_cfg);
      col = column_pos % DEF_MAX_INNER;
      last_r = reduce_pos + 1 >= n;
      last_c = column_pos + 1 >= k;
      if (reduce_pos == 0) begin
         column_best[col] = sample;
         column_best_at[col] = 16'd0;
      end else if (!is_nan(sample) && !is_nan(column_best[col])
                   && float_key(column_best[col]) < float_key(sample)) begin
         column_best[col] = sample;
         column_best_at[col] = reduce_pos[15:0];
      end
      if (last_r) begin
         r.index = column_best_at[col];
         r.last = last_c;
         expected_argmax.push_back(r);
      end
      if (last_c) begin
         column_pos = 0;
         reduce_pos = last_r ? 0 : reduce_pos + 1;
      end else begin
         column_pos = column_pos + 1;
      end
   endtask

   function automatic logic [31:0] draw_sample(input logic [31:0] prev);
      logic [31:0] s;
      s = $urandom;
      case ($urandom_range(0, 9))
         5: s = prev;
         6: case ($urandom_range(0, 5))
               0: s = 32'h0000_0000;
               1: s = 32'h8000_0000;
               2: s = 32'h7f80_0000;
               3: s = 32'hff80_0000;
               4: s = 32'h7f7f_ffff;
               default: s = 32'hff7f_ffff;
            endcase
         7: s = {s[31], 8'hff, (s[22:0] == 0) ? 23'd1 : s[22:0]};
         8: s = {s[31], 8'h7e + 8'($urandom_range(0, 2)), s[22:0]};
         9: s = {~prev[31], prev[30:0]};
         default: ;
      endcase
      return s;
   endfunction

   // Drain everything in flight, then hold for the pipeline to settle.
   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_if.valid || expected_argmax.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == CSR_REDUCE_LENGTH) reduce_cfg = value[REDUCE_CFG_W-1:0];
      else inner_cfg = value[INNER_CFG_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_pressure();
      max_send_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
      max_recv_stall = ($urandom_range(0, 3) == 0) ? 0 : 10;
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         last_sample = draw_sample(last_sample);
         pending_samples.push_back(last_sample);
      end
   endtask

   // Driver: present beats at the falling edge, hold until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fire) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_if.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
         req_if.valid <= 1'b1;
         req_if.data <= pending_samples.pop_front();
         send_gap <= $urandom_range(0, max_send_gap);
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (rsp_fire) recv_stall = $urandom_range(0, max_recv_stall);
      if (reset || recv_stall > 0) begin
         rsp_if.ready <= 1'b0;
         if (!reset) recv_stall = recv_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: sample both channels at the rising edge.
   always @(posedge clock) begin
      argmax_result_type want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      rsp_fire <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         beats_in++;
         predict_argmax(req_if.data);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_out++;
         if (expected_argmax.size() == 0) begin
            errors++;
            $display("%0t: unexpected result index %0d last %0b", $time,
                     rsp_if.data[15:0], rsp_if.data[16]);
         end else begin
            want = expected_argmax.pop_front();
            if (want.index !== rsp_if.data[15:0]) begin
               errors++;
               $display("%0t: argmax_index expected %0d actual %0d", $time,
                        want.index, rsp_if.data[15:0]);
            end
            if (want.last !== rsp_if.data[16]) begin
               errors++;
               $display("%0t: last_of_group expected %0b actual %0b", $time,
                        want.last, rsp_if.data[16]);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int r_len;
      int k_len;
      int groups;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_REDUCE_LENGTH;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      send_gap = 0;
      recv_stall = 0;
      max_send_gap = 10;
      max_recv_stall = 10;
      errors = 0;
      beats_in = 0;
      results_out = 0;
      column_pos = 0;
      reduce_pos = 0;
      reduce_cfg = 1;
      inner_cfg = 1;
      last_sample = 32'h3f80_0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // leading NaN, ties, signed zeros and infinities across two columns
      write_csr(CSR_REDUCE_LENGTH, CSR_DATA_W'(4));
      write_csr(CSR_INNER_LENGTH, CSR_DATA_W'(2));
      pending_samples = '{32'h7fc0_0000, 32'h8000_0000, 32'h3f80_0000, 32'h0000_0000,
                          32'h3f80_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7f80_0000};
      wait_idle();

      // zero reduce length, oversized inner length, then shrink mid-group
      write_csr(CSR_REDUCE_LENGTH, CSR_DATA_W'(0));
      write_csr(CSR_INNER_LENGTH, CSR_DATA_W'(9'h1ff));
      queue_random(258);
      wait_idle();
      write_csr(CSR_INNER_LENGTH, CSR_DATA_W'(0));
      queue_random(3);
      wait_idle();

      // oversized reduce length, then shrink it part way down the axis
      write_csr(CSR_REDUCE_LENGTH, CSR_DATA_W'(17'h1ffff));
      write_csr(CSR_INNER_LENGTH, CSR_DATA_W'(1));
      queue_random(30);
      wait_idle();
      write_csr(CSR_REDUCE_LENGTH, CSR_DATA_W'(2));
      queue_random(1);
      wait_idle();

      while (beats_in < 1800) begin
         case ($urandom_range(0, 9))
            0: begin r_len = $urandom_range(1, 2); k_len = $urandom_range(128, 256); end
            1: begin r_len = $urandom_range(20, 60); k_len = $urandom_range(1, 3); end
            default: begin r_len = $urandom_range(1, 8); k_len = $urandom_range(1, 12); end
         endcase
         groups = (r_len * k_len > 100) ? 1 : $urandom_range(1, 4);
         set_pressure();
         write_csr(CSR_REDUCE_LENGTH,
                   CSR_DATA_W'((r_len == 1 && $urandom_range(0, 1)) ? 0 : r_len));
         write_csr(CSR_INNER_LENGTH, CSR_DATA_W'(k_len));
         queue_random(groups * r_len * k_len);
         wait_idle();
      end

      $display("Sent %0d sample beats, checked %0d argmax results", beats_in, results_out);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
